/* design/spvt_pkg.sv */
package spvt_pkg;

	localparam int PRIO_W = 16;
	localparam int VAL_W  = 8;
	localparam int RANK_W = 3;

	typedef logic [PRIO_W-1:0] prio_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [RANK_W-1:0] rank_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_WRITE,
		ST_DROP,
		ST_INSERT,
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic find;
		logic write;
		logic drop;
		logic insert;
		logic load;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic last_rank;
	} sts_t;

endpackage

/* design/spvt_if.sv */
interface spvt_in_if;
	logic                valid;
	logic                ready;
	spvt_pkg::prio_t     priority_req;
	spvt_pkg::val_t      value;

	modport source (output valid, output priority_req, output value, input ready);
	modport sink   (input valid, input priority_req, input value, output ready);
endinterface

interface spvt_out_if;
	logic                valid;
	logic                ready;
	spvt_pkg::rank_t     rank;
	spvt_pkg::val_t      slot_value;
	logic                rejected;
	logic                last;

	modport source (output valid, output rank, output slot_value, output rejected,
		output last, input ready);
	modport sink   (input valid, input rank, input slot_value, input rejected,
		input last, output ready);
endinterface

/* design/spvt_ctrl.sv */
module spvt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  spvt_pkg::sts_t   sts,
	output spvt_pkg::cmd_t   cmd
);

	spvt_pkg::state_t state_q;
	spvt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spvt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			spvt_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = spvt_pkg::ST_FIND;
				end
			end
			spvt_pkg::ST_FIND: begin
				cmd.find = 1'b1;
				state_d  = spvt_pkg::ST_WRITE;
			end
			spvt_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = spvt_pkg::ST_DROP;
			end
			spvt_pkg::ST_DROP: begin
				cmd.drop = 1'b1;
				state_d  = spvt_pkg::ST_INSERT;
			end
			spvt_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = spvt_pkg::ST_LOAD;
			end
			spvt_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = spvt_pkg::ST_EMIT;
			end
			spvt_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.shift = out_ready;
				if (out_ready && sts.last_rank) begin
					state_d = spvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spvt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* design/spvt_dp.sv */
module spvt_dp #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spvt_pkg::cmd_t    cmd,
	output spvt_pkg::sts_t    sts,
	input  spvt_pkg::prio_t   priority_req,
	input  spvt_pkg::val_t    value,
	output spvt_pkg::rank_t   rank,
	output spvt_pkg::val_t    slot_value,
	output logic              rejected,
	output logic              last
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	spvt_pkg::prio_t prio_q [DEPTH];
	spvt_pkg::val_t  val_q  [DEPTH];
	logic [CNTW-1:0] count_q;

	spvt_pkg::prio_t req_prio_q;
	spvt_pkg::val_t  req_val_q;

	logic [IW-1:0]   vi_q;
	logic [IW-1:0]   pi_q;
	logic            wr_en_q;
	logic            drop_en_q;
	logic            ins_en_q;
	logic            rej_q;

	spvt_pkg::val_t  snap_q [DEPTH];
	logic [IW-1:0]   rank_q;

	logic [DEPTH-1:0] valid;
	logic [DEPTH-1:0] vhit_vec;
	logic [DEPTH-1:0] phit_vec;
	logic [DEPTH-1:0] keep;
	logic [DEPTH-1:0] keep_dn;
	logic [IW-1:0]    vi;
	logic [IW-1:0]    pi;
	logic             vhit;
	logic             phit;
	logic             wr_en;
	logic             drop_en;
	logic             ins_en;
	logic             rej;

	spvt_pkg::prio_t up_prio [DEPTH];
	spvt_pkg::val_t  up_val  [DEPTH];
	spvt_pkg::prio_t dn_prio [DEPTH];
	spvt_pkg::val_t  dn_val  [DEPTH];
	spvt_pkg::val_t  snap_up [DEPTH];

	logic [IW+2:0]   rank_ext;

	// Per-slot compares; values and priorities are unique, so any hit is the hit
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid[i]    = CNTW'(i) < count_q;
			vhit_vec[i] = valid[i] && (val_q[i] == req_val_q);
			phit_vec[i] = valid[i] && (prio_q[i] == req_prio_q);
			keep[i]     = valid[i] && (prio_q[i] > req_prio_q);
		end
		vi = '0;
		pi = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (vhit_vec[i]) begin
				vi = IW'(i);
			end
			if (phit_vec[i]) begin
				pi = IW'(i);
			end
		end
		vhit = |vhit_vec;
		phit = |phit_vec;
	end

	always_comb begin
		wr_en   = 1'b0;
		drop_en = 1'b0;
		ins_en  = 1'b0;
		rej     = 1'b0;
		if (req_prio_q == '0) begin
			drop_en = vhit;
		end else if (phit) begin
			wr_en   = !(vhit && (vi == pi));
			drop_en = vhit && (vi != pi);
		end else if (vhit) begin
			drop_en = 1'b1;
			ins_en  = 1'b1;
		end else if (count_q < CNTW'(DEPTH)) begin
			ins_en = 1'b1;
		end else begin
			rej = 1'b1;
		end
	end

	// Neighbor views of the table for compaction and insertion
	always_comb begin
		for (int j = 0; j < DEPTH - 1; j++) begin
			up_prio[j] = prio_q[j+1];
			up_val[j]  = val_q[j+1];
			snap_up[j] = snap_q[j+1];
		end
		up_prio[DEPTH-1] = '0;
		up_val[DEPTH-1]  = '0;
		snap_up[DEPTH-1] = '0;
		dn_prio[0] = '0;
		dn_val[0]  = '0;
		keep_dn[0] = 1'b1;
		for (int j = 1; j < DEPTH; j++) begin
			dn_prio[j] = prio_q[j-1];
			dn_val[j]  = val_q[j-1];
			keep_dn[j] = keep[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) begin
				prio_q[j] <= '0;
				val_q[j]  <= '0;
			end
			count_q   <= '0;
			wr_en_q   <= 1'b0;
			drop_en_q <= 1'b0;
			ins_en_q  <= 1'b0;
			rej_q     <= 1'b0;
			rank_q    <= '0;
		end else begin
			if (cmd.find) begin
				wr_en_q   <= wr_en;
				drop_en_q <= drop_en;
				ins_en_q  <= ins_en;
				rej_q     <= rej;
			end
			if (cmd.write && wr_en_q) begin
				val_q[pi_q] <= req_val_q;
			end
			if (cmd.drop && drop_en_q) begin
				// close the gap; the zero tail moves up behind it
				for (int j = 0; j < DEPTH; j++) begin
					if (IW'(j) >= vi_q) begin
						prio_q[j] <= up_prio[j];
						val_q[j]  <= up_val[j];
					end
				end
				count_q <= count_q - 1'b1;
			end
			if (cmd.insert && ins_en_q) begin
				for (int j = 0; j < DEPTH; j++) begin
					if (!keep[j]) begin
						if (keep_dn[j]) begin
							prio_q[j] <= req_prio_q;
							val_q[j]  <= req_val_q;
						end else begin
							prio_q[j] <= dn_prio[j];
							val_q[j]  <= dn_val[j];
						end
					end
				end
				count_q <= count_q + 1'b1;
			end
			if (cmd.load) begin
				rank_q <= '0;
			end else if (cmd.shift) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_prio_q <= priority_req;
			req_val_q  <= value;
		end
		if (cmd.find) begin
			vi_q <= vi;
			pi_q <= pi;
		end
		if (cmd.load) begin
			for (int j = 0; j < DEPTH; j++) begin
				snap_q[j] <= valid[j] ? val_q[j] : '0;
			end
		end else if (cmd.shift) begin
			for (int j = 0; j < DEPTH; j++) begin
				snap_q[j] <= snap_up[j];
			end
		end
	end

	assign rank_ext      = (IW + 3)'(rank_q);
	assign rank          = rank_ext[2:0];
	assign slot_value    = snap_q[0];
	assign rejected      = rej_q;
	assign last          = rank_q == IW'(DEPTH - 1);
	assign sts.last_rank = last;

endmodule

/* design/sorted_priority_value_table_unit.sv */
// Sorted priority table of DEPTH entries, each a unique nonzero priority paired with a
// unique value. Each accepted item (priority_req, value) may delete, replace, move or
// insert an entry, then the full table is listed as DEPTH result items from the
// highest priority down, empty slots reading 0 and all items flagged rejected when an
// insert found the table full. The update runs as a fixed sequence of five steps
// (lookup, value write, compaction, insertion, snapshot) in a controller/datapath
// pair, followed by one result per cycle while the sink is ready; the block takes the
// next item once the last rank has gone out.
module sorted_priority_value_table_unit #(
	parameter int DEPTH = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	spvt_in_if.sink    in_ch,
	spvt_out_if.source out_ch
);

	spvt_pkg::cmd_t cmd;
	spvt_pkg::sts_t sts;

	spvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spvt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.priority_req (in_ch.priority_req),
		.value        (in_ch.value),
		.rank         (out_ch.rank),
		.slot_value   (out_ch.slot_value),
		.rejected     (out_ch.rejected),
		.last         (out_ch.last)
	);

endmodule

/* design/spvt_checker.sv */
module spvt_checker #(
	parameter int DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  spvt_pkg::rank_t      rank,
	input  logic                 rejected,
	input  logic                 last
);

	// one item in flight: no intake while a listing is out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while listing active");

	a_take_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an item was taken");

	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> rank == 3'((DEPTH - 1) % 8))
		else $error("last flagged on wrong rank");

	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=>
			out_valid && rank == 3'($past(rank) + 3'd1) && rejected == $past(rejected))
		else $error("listing broke off or skipped a rank");

endmodule

bind sorted_priority_value_table_unit spvt_checker #(
	.DEPTH (DEPTH)
) u_spvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.rank      (out_ch.rank),
	.rejected  (out_ch.rejected),
	.last      (out_ch.last)
);
